// ===== rtl/efc_pkg.sv =====
`default_nettype none

package efc_pkg;

  localparam int unsigned PosWidth = 17;
  localparam int unsigned LenWidth = 17;
  localparam int unsigned MacWidth = 48;
  localparam int unsigned IpWidth  = 32;
  localparam int unsigned RepWidth = 32;
  localparam int unsigned NumKinds = 5;

  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 248;
  localparam int unsigned OutUserWidth = 3;

  typedef enum logic [2:0] {
    KindIpv4    = 3'd0,
    KindEth2    = 3'd1,
    KindRaw8023 = 3'd2,
    KindSnap    = 3'd3,
    KindLlc     = 3'd4
  } kind_e;

  localparam logic [15:0] TypeIpv4   = 16'h0800;
  localparam logic [15:0] TypeMaxLen = 16'h05FE;
  localparam logic [15:0] LlcRaw     = 16'hFFFF;
  localparam logic [15:0] LlcSnap    = 16'hAAAA;

  localparam logic [LenWidth-1:0] HeaderLen = 17'd14;
  localparam logic [LenWidth-1:0] IpMinLen  = 17'd34;
  localparam logic [LenWidth-1:0] LlcMinLen = 17'd16;

  localparam logic [PosWidth-1:0] PosSrcMac  = 17'd6;
  localparam logic [PosWidth-1:0] PosType    = 17'd12;
  localparam logic [PosWidth-1:0] PosLlc     = 17'd14;
  localparam logic [PosWidth-1:0] PosIpLen   = 17'd16;
  localparam logic [PosWidth-1:0] PosIpLenE  = 17'd18;
  localparam logic [PosWidth-1:0] PosSrcIp   = 17'd26;
  localparam logic [PosWidth-1:0] PosDstIp   = 17'd30;
  localparam logic [PosWidth-1:0] PosIpEnd   = 17'd34;
  localparam logic [PosWidth-1:0] PosKnownIp = 17'd17;
  localparam logic [PosWidth-1:0] PosKnownE2 = 17'd13;
  localparam logic [PosWidth-1:0] PosKnownLl = 17'd15;

endpackage

`default_nettype wire

// ===== rtl/ethernet_frame_classifier.sv =====
`default_nettype none

// Classifies a byte stream of back-to-back Ethernet frames. One byte enters per cycle on the
// slave side while the output is not stalled; tlast marks the last byte of the capture. The
// block holds the MACs, type/length, the word at offset 14, the IPv4 total length and IPv4
// addresses of the frame in flight, and on the frame's last byte (or at capture end, flagged
// truncated) it sends one record carrying kind, length, addresses and saturating frame and
// per-kind counts. Each byte passes an input register, one pass of header update and length
// compare, and the frame's record lands in the record register. Both registers stall together
// when the master side holds tready low. No clearing pass follows reset.
module ethernet_frame_classifier #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [7:0] data_byte
  input  wire logic [efc_pkg::InDataWidth-1:0]   s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [16:0] frame_length, [64:17] dest_mac, [112:65] source_mac, [144:113] source_ip,
  // [176:145] dest_ip, [208:177] frame_index, [240:209] kind_count, [241] length_guessed,
  // [242] truncated, [247:243] zero
  output      logic [efc_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // [2:0] frame_kind
  output      logic [efc_pkg::OutUserWidth-1:0]  m_axis_tuser
);
  import efc_pkg::*;

  logic                   in_valid_q;
  logic [7:0]             in_data_q;
  logic                   in_last_q;
  logic                   adv;
  logic                   proc;

  logic [PosWidth-1:0]    pos_q, pos_d;
  logic [MacWidth-1:0]    dmac_q, dmac_n, dmac_d;
  logic [MacWidth-1:0]    smac_q, smac_n, smac_d;
  logic [15:0]            type_q, type_n, type_d;
  logic [15:0]            llc_q, llc_n, llc_d;
  logic [15:0]            iplen_q, iplen_n, iplen_d;
  logic [IpWidth-1:0]     sip_q, sip_n, sip_d;
  logic [IpWidth-1:0]     dip_q, dip_n, dip_d;

  logic [COUNTER_WIDTH-1:0] fc_q, fc_inc;
  logic [COUNTER_WIDTH-1:0] kc_q [NumKinds];
  logic [COUNTER_WIDTH-1:0] kc_sel, kc_inc;
  logic [RepWidth-1:0]      fi_rep, kc_rep;

  kind_e                  kind;
  logic [LenWidth-1:0]    len;
  logic [LenWidth-1:0]    sum_ip, sum_ll;
  logic                   known;
  logic                   done;
  logic                   emit;

  logic                   out_valid_q;
  kind_e                  out_kind_q;
  logic [LenWidth-1:0]    out_len_q;
  logic [MacWidth-1:0]    out_dmac_q, out_smac_q;
  logic [IpWidth-1:0]     out_sip_q, out_dip_q;
  logic [RepWidth-1:0]    out_fi_q, out_kc_q;
  logic                   out_guess_q, out_trunc_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;
  assign proc          = in_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_comb begin
    dmac_n  = dmac_q;
    smac_n  = smac_q;
    type_n  = type_q;
    llc_n   = llc_q;
    iplen_n = iplen_q;
    sip_n   = sip_q;
    dip_n   = dip_q;
    if (pos_q < PosSrcMac) begin
      dmac_n = {dmac_q[MacWidth-9:0], in_data_q};
    end else if (pos_q < PosType) begin
      smac_n = {smac_q[MacWidth-9:0], in_data_q};
    end else if (pos_q < PosLlc) begin
      type_n = {type_q[7:0], in_data_q};
    end else if (pos_q < PosIpLen) begin
      llc_n = {llc_q[7:0], in_data_q};
    end else if (pos_q < PosIpLenE) begin
      iplen_n = {iplen_q[7:0], in_data_q};
    end else if (pos_q >= PosSrcIp && pos_q < PosDstIp) begin
      sip_n = {sip_q[IpWidth-9:0], in_data_q};
    end else if (pos_q >= PosDstIp && pos_q < PosIpEnd) begin
      dip_n = {dip_q[IpWidth-9:0], in_data_q};
    end
  end

  assign sum_ip = {1'b0, iplen_n} + HeaderLen;
  assign sum_ll = {1'b0, type_n} + HeaderLen;

  always_comb begin
    if (type_n == TypeIpv4) begin
      kind  = KindIpv4;
      len   = (sum_ip < IpMinLen) ? IpMinLen : sum_ip;
      known = pos_q >= PosKnownIp;
    end else if (type_n > TypeMaxLen) begin
      kind  = KindEth2;
      len   = HeaderLen;
      known = pos_q >= PosKnownE2;
    end else begin
      len   = (sum_ll < LlcMinLen) ? LlcMinLen : sum_ll;
      known = pos_q >= PosKnownLl;
      if (llc_n == LlcRaw) begin
        kind = KindRaw8023;
      end else if (llc_n == LlcSnap) begin
        kind = KindSnap;
      end else begin
        kind = KindLlc;
      end
    end
  end

  assign done = known && (({1'b0, pos_q} + 18'd1) >= {1'b0, len});
  assign emit = done || in_last_q;

  assign pos_d  = emit ? '0 : pos_q + 1'b1;
  assign dmac_d  = emit ? '0 : dmac_n;
  assign smac_d  = emit ? '0 : smac_n;
  assign type_d  = emit ? '0 : type_n;
  assign llc_d   = emit ? '0 : llc_n;
  assign iplen_d = emit ? '0 : iplen_n;
  assign sip_d   = emit ? '0 : sip_n;
  assign dip_d   = emit ? '0 : dip_n;

  assign kc_sel = kc_q[kind];
  assign fc_inc = (&fc_q) ? fc_q : fc_q + 1'b1;
  assign kc_inc = (&kc_sel) ? kc_sel : kc_sel + 1'b1;

  if (COUNTER_WIDTH > RepWidth) begin : g_rep_wide
    assign fi_rep = (|fc_inc[COUNTER_WIDTH-1:RepWidth]) ? '1 : fc_inc[RepWidth-1:0];
    assign kc_rep = (|kc_inc[COUNTER_WIDTH-1:RepWidth]) ? '1 : kc_inc[RepWidth-1:0];
  end else begin : g_rep_narrow
    assign fi_rep = RepWidth'(fc_inc);
    assign kc_rep = RepWidth'(kc_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      dmac_q  <= '0;
      smac_q  <= '0;
      type_q  <= '0;
      llc_q   <= '0;
      iplen_q <= '0;
      sip_q   <= '0;
      dip_q   <= '0;
      fc_q    <= '0;
      for (int k = 0; k < NumKinds; k++) begin
        kc_q[k] <= '0;
      end
    end else if (proc) begin
      pos_q   <= pos_d;
      dmac_q  <= dmac_d;
      smac_q  <= smac_d;
      type_q  <= type_d;
      llc_q   <= llc_d;
      iplen_q <= iplen_d;
      sip_q   <= sip_d;
      dip_q   <= dip_d;
      if (emit) begin
        fc_q       <= fc_inc;
        kc_q[kind] <= kc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_kind_q  <= kind;
      out_len_q   <= len;
      out_dmac_q  <= dmac_n;
      out_smac_q  <= smac_n;
      out_sip_q   <= (kind == KindIpv4) ? sip_n : '0;
      out_dip_q   <= (kind == KindIpv4) ? dip_n : '0;
      out_fi_q    <= fi_rep;
      out_kc_q    <= kc_rep;
      out_guess_q <= (kind == KindEth2);
      out_trunc_q <= !done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {5'd0, out_trunc_q, out_guess_q, out_kc_q, out_fi_q, out_dip_q,
                          out_sip_q, out_smac_q, out_dmac_q, out_len_q};

  a_ipv4_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KindIpv4) |-> (out_len_q >= IpMinLen))
    else $error("IPv4 record shorter than its header");

  a_guess_eth2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_guess_q == (out_kind_q == KindEth2)))
    else $error("length guess flag does not match kind");

  a_kind_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_kc_q <= out_fi_q))
    else $error("kind count exceeds frame count");

  a_ip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KindIpv4) |-> (out_sip_q == '0 && out_dip_q == '0))
    else $error("IP addresses reported for non-IPv4 frame");

endmodule

`default_nettype wire
